### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when cond holds, expr holds too.
`define ASSERT_IMPLY(lbl, clk, rst, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when cond holds, expr holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/rfr_pkg.sv
package rfr_pkg;

  // Input word kinds carried on tuser
  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  // Result status carried on tuser
  localparam logic STATUS_FRAME   = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  // Frame format
  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] END_BYTE   = 8'hEF;
  localparam int         FRAME_LEN  = 10;

  // Byte positions of interest inside the frame
  localparam logic [3:0] POS_START   = 4'd0;
  localparam logic [3:0] POS_SUM_END = 4'd6;
  localparam logic [3:0] POS_CMD     = 4'd3;
  localparam logic [3:0] POS_PAR_HI  = 4'd5;
  localparam logic [3:0] POS_PAR_LO  = 4'd6;
  localparam logic [3:0] POS_CHK_HI  = 4'd7;
  localparam logic [3:0] POS_CHK_LO  = 4'd8;
  localparam logic [3:0] POS_LAST    = 4'(FRAME_LEN - 1);

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  data_byte;
    op_t         op;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic        status;
    logic [7:0]  command;
    logic [15:0] parameter_res;
  } result_t;

endpackage

### hdl/rfr_core.sv
module rfr_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  rfr_pkg::item_t  item,
  output rfr_pkg::result_t res
);

  logic        waiting, waiting_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  held_command, held_command_next;
  logic [15:0] held_parameter, held_parameter_next;
  logic [15:0] received_checksum, received_checksum_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [15:0] limit_ms, limit_ms_next;

  logic [15:0] calc_checksum;
  logic [15:0] elapsed_inc;

  assign calc_checksum = 16'(16'd0 - running_sum);
  assign elapsed_inc   = (elapsed_ms < limit_ms) ? 16'(elapsed_ms + 16'd1) : elapsed_ms;

  // Next state and result for the item in the input register
  always_comb begin
    waiting_next           = waiting;
    byte_position_next     = byte_position;
    running_sum_next       = running_sum;
    held_command_next      = held_command;
    held_parameter_next    = held_parameter;
    received_checksum_next = received_checksum;
    elapsed_ms_next        = elapsed_ms;
    limit_ms_next          = limit_ms;
    res                    = '0;

    case (item.op)
      rfr_pkg::OP_ARM: begin
        waiting_next       = 1'b1;
        byte_position_next = rfr_pkg::POS_START;
        running_sum_next   = '0;
        elapsed_ms_next    = '0;
        limit_ms_next      = item.timeout_ms;
        if (item.timeout_ms == 16'd0) begin
          res.valid    = 1'b1;
          res.status   = rfr_pkg::STATUS_TIMEOUT;
          waiting_next = 1'b0;
        end
      end
      rfr_pkg::OP_BYTE: begin
        if (waiting) begin
          if (byte_position == rfr_pkg::POS_START) begin
            // hunt for the start byte
            if (item.data_byte == rfr_pkg::START_BYTE) begin
              running_sum_next   = '0;
              byte_position_next = 4'd1;
            end
          end else begin
            if (byte_position <= rfr_pkg::POS_SUM_END) begin
              running_sum_next = 16'(running_sum + {8'd0, item.data_byte});
            end
            case (byte_position)
              rfr_pkg::POS_CMD:    held_command_next = item.data_byte;
              rfr_pkg::POS_PAR_HI: held_parameter_next[15:8] = item.data_byte;
              rfr_pkg::POS_PAR_LO: held_parameter_next[7:0] = item.data_byte;
              rfr_pkg::POS_CHK_HI: received_checksum_next[15:8] = item.data_byte;
              rfr_pkg::POS_CHK_LO: received_checksum_next[7:0] = item.data_byte;
              default: ;
            endcase
            if (byte_position >= rfr_pkg::POS_LAST) begin
              // last byte: check trailer and checksum, restart either way
              byte_position_next = rfr_pkg::POS_START;
              running_sum_next   = '0;
              if (item.data_byte == rfr_pkg::END_BYTE &&
                  received_checksum == calc_checksum) begin
                res.valid         = 1'b1;
                res.status        = rfr_pkg::STATUS_FRAME;
                res.command       = held_command;
                res.parameter_res = held_parameter;
                waiting_next      = 1'b0;
              end
            end else begin
              byte_position_next = 4'(byte_position + 4'd1);
            end
          end
        end
      end
      rfr_pkg::OP_TICK: begin
        if (waiting) begin
          elapsed_ms_next = elapsed_inc;
          if (elapsed_inc >= limit_ms) begin
            res.valid    = 1'b1;
            res.status   = rfr_pkg::STATUS_TIMEOUT;
            waiting_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting       <= 1'b0;
      byte_position <= rfr_pkg::POS_START;
    end else if (step) begin
      waiting       <= waiting_next;
      byte_position <= byte_position_next;
    end
  end

  // Frame and timer data
  always_ff @(posedge clk) begin
    if (step) begin
      running_sum       <= running_sum_next;
      held_command      <= held_command_next;
      held_parameter    <= held_parameter_next;
      received_checksum <= received_checksum_next;
      elapsed_ms        <= elapsed_ms_next;
      limit_ms          <= limit_ms_next;
    end
  end

endmodule

### hdl/response_frame_receiver.sv
// Response frame receiver.
// Input stream: one word per serial event. tuser selects the kind: arm a wait
// (tdata carries the millisecond limit), a received byte, or a 1 ms tick.
// While armed, bytes are dropped until 0x7E, which opens a ten-byte frame that
// passes when byte 9 is 0xEF and bytes 7..8 equal the negated 16-bit sum of
// bytes 1..6. A passing frame, a reached limit, or an arm with limit 0 ends
// the wait with one output word; nothing else produces output.
// Output stream: tuser is the status (0 frame, 1 timeout), tdata holds the
// command and parameter (both zero on timeout).
// Path: an accepted word lands in the input register, the state update is
// combinational between the registers, and the result is loaded into the
// output register when the word advances. Throughput is one word per cycle
// while the output is not stalled.
// Reset (rst, synchronous) empties both registers and leaves the block idle.
// When the output is stalled the pending input word waits in the input
// register and s_axis_tready drops until the output word is taken.
module response_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] timeout_ms
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] command, [23:8] parameter_res
  output logic        m_axis_tuser    // [0] status
);

  logic             in_valid;
  rfr_pkg::item_t   in_item;
  rfr_pkg::result_t res;
  logic             advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.op         <= rfr_pkg::op_t'(s_axis_tuser);
      in_item.data_byte  <= s_axis_tdata[7:0];
      in_item.timeout_ms <= s_axis_tdata[23:8];
    end
  end

  rfr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .res  (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= res.valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_axis_tuser <= res.status;
      m_axis_tdata <= {res.parameter_res, res.command};
    end
  end

endmodule

### hdl/rfr_checker.sv
`include "assert_macros.svh"

module rfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic stalled;
  assign stalled = m_axis_tvalid && !m_axis_tready;

  // Output word is held while stalled
  `ASSERT_NEXT(a_out_valid_hold, clk, rst, stalled, m_axis_tvalid)
  `ASSERT_NEXT(a_out_data_hold, clk, rst, stalled,
    $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // Reset empties the output register
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid)
  // Timeout words carry no command or parameter
  `ASSERT_IMPLY(a_timeout_zero, clk, rst,
    m_axis_tvalid && (m_axis_tuser == rfr_pkg::STATUS_TIMEOUT), m_axis_tdata == 24'd0)
  // With the output register empty, input is never blocked
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready)

endmodule

bind response_frame_receiver rfr_checker u_rfr_checker (.*);
